// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pattern generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/epg_pkg.sv =====
// ----------------------------------------------------------------------------
// Euclidean pattern generator package
// Widths, state codes and the request type of the shared reduce unit.
// ----------------------------------------------------------------------------
`default_nettype none

package epg_pkg;

	localparam int MASK_W = 32;
	localparam int LEN_W  = 6;
	localparam int POS_W  = 5;
	localparam int ROT_W  = 16;
	localparam int CNT_W  = 5;

	localparam logic [MASK_W-1:0] MASK_ALL = '1;
	localparam logic [CNT_W-1:0]  MOD_LAST = CNT_W'(ROT_W - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOD  = 4'b0010,
		ST_GEN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] num;
		logic [LEN_W-1:0] modulus;
	} red_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/euclidean_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// Euclidean pattern generator
// Spreads pulses over steps in Bresenham form and rotates the hit mask.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// item in   start / busy     step_count, pulse_count, rotate_by
// result    done (strobe)    hit_mask
//
// An item first takes the floored remainder of the rotation (one bit a
// cycle through the shared reduce unit), then one step a cycle over the
// clamped length, then one cycle with done high.
// busy is high from the cycle after acceptance through the done cycle.
// Reset clears the sequencer only. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module euclidean_pattern_generator
	import epg_pkg::*;
#(
	parameter int MAX_STEPS = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  wire  [LEN_W-1:0] step_count,
	input  wire  [LEN_W-1:0] pulse_count,
	input  wire  [ROT_W-1:0] rotate_by,
	output logic             done,
	output logic [MASK_W-1:0] hit_mask
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_STEPS);

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  hits_q;
	logic [ROT_W-1:0]  mag_q;
	logic              neg_q;
	logic [POS_W-1:0]  rem_q;
	logic [POS_W-1:0]  acc_q;
	logic [POS_W-1:0]  pos_q;
	logic [MASK_W-1:0] mask_q;

	logic [LEN_W-1:0]  len_c;
	logic [LEN_W-1:0]  hits_c;
	logic [LEN_W-1:0]  wrap_pos;
	red_req_t          red_req;
	logic [POS_W-1:0]  red_res;
	logic [LEN_W-1:0]  fix_c;

	epg_reduce u_reduce (
		.req (red_req),
		.res (red_res)
	);

	always_comb begin
		if (step_count == '0) begin
			len_c = LEN_W'(1);
		end else if (step_count > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = step_count;
		end
		hits_c = (pulse_count > len_c) ? len_c : pulse_count;
	end

	always_comb begin
		red_req.modulus = len_q;
		if (state_q == ST_MOD) begin
			red_req.num = {rem_q, mag_q[ROT_W-1]};
		end else begin
			red_req.num = {1'b0, acc_q} + hits_q;
		end
		fix_c    = len_q - {1'b0, red_res};
		wrap_pos = len_q - LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MOD;
						cnt_q   <= MOD_LAST;
					end
				end
				ST_MOD: begin
					if (cnt_q == '0) begin
						state_q <= ST_GEN;
						cnt_q   <= wrap_pos[CNT_W-1:0];
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_GEN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					len_q  <= len_c;
					hits_q <= hits_c;
					neg_q  <= rotate_by[ROT_W-1];
					mag_q  <= rotate_by[ROT_W-1] ? (~rotate_by + ROT_W'(1)) : rotate_by;
					rem_q  <= '0;
				end
			end
			ST_MOD: begin
				rem_q <= red_res;
				mag_q <= {mag_q[ROT_W-2:0], 1'b0};
				if (cnt_q == '0) begin
					acc_q  <= '0;
					mask_q <= '0;
					if (neg_q && red_res != '0) begin
						pos_q <= fix_c[POS_W-1:0];
					end else begin
						pos_q <= red_res;
					end
				end
			end
			ST_GEN: begin
				mask_q[pos_q] <= ({1'b0, acc_q} < hits_q);
				acc_q         <= red_res;
				if ({1'b0, pos_q} == wrap_pos) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);
	assign hit_mask = mask_q;

	`EPG_ASSERT_IMPL(a_mask_window, clk, arst_n, done, (hit_mask & (MASK_ALL << len_q)) == '0)
	`EPG_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`EPG_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy && !done)

endmodule

`default_nettype wire

// ===== rtl/core/epg_reduce.sv =====
// ----------------------------------------------------------------------------
// Shared reduce unit
// One compare and conditional subtract: num mod modulus for num < 2*modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module epg_reduce
	import epg_pkg::*;
(
	input  wire red_req_t         req,
	output logic      [POS_W-1:0] res
);

	logic [LEN_W-1:0] diff;

	always_comb begin
		diff = req.num - req.modulus;
		if (req.num >= req.modulus) begin
			res = diff[POS_W-1:0];
		end else begin
			res = req.num[POS_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_euclidean_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// Euclidean pattern generator testbench
// Sends step/pulse/rotation items through the start/busy handshake, predicts
// each hit mask from the clamped length, the spread of the pulses and the
// floored rotation, and checks every done strobe against the oldest
// prediction. A directed part covers the clamps, the empty and the full
// patterns and the rotation extremes; random parts follow with sender gaps,
// a full drain pause and a final back-to-back stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euclidean_pattern_generator;
	import epg_pkg::*;

	localparam int MAX_STEPS   = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 60;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [LEN_W-1:0]  step_count;
	logic [LEN_W-1:0]  pulse_count;
	logic [ROT_W-1:0]  rotate_by;
	logic              done;
	logic [MASK_W-1:0] hit_mask;

	logic [MASK_W-1:0] pending_masks[$];
	int                items_sent;
	int                masks_checked;
	int                error_count;
	int                cycle_count;
	bit                gaps_enabled;

	euclidean_pattern_generator #(
		.MAX_STEPS(MAX_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.step_count(step_count),
		.pulse_count(pulse_count),
		.rotate_by(rotate_by),
		.done(done),
		.hit_mask(hit_mask)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [MASK_W-1:0] predict_hit_mask(
		input logic [LEN_W-1:0] steps_in,
		input logic [LEN_W-1:0] pulses_in,
		input logic [ROT_W-1:0] rot_in
	);
		int len;
		int hits;
		int shift;
		logic [MASK_W-1:0] spread;
		logic [MASK_W-1:0] rotated;
		len = steps_in;
		if (len < 1)
			len = 1;
		if (len > MAX_STEPS)
			len = MAX_STEPS;
		hits = pulses_in;
		if (hits > len)
			hits = len;
		if (hits == 0)
			return '0;
		if (hits >= len)
			return MASK_ALL >> (MASK_W - len);
		shift = int'($signed(rot_in)) % len;
		if (shift < 0)
			shift += len;
		spread = '0;
		rotated = '0;
		for (int i = 0; i < len; i++) begin
			if ((i * hits) % len < hits)
				spread[i] = 1'b1;
		end
		for (int i = 0; i < len; i++) begin
			if (spread[i])
				rotated[(i + shift) % len] = 1'b1;
		end
		return rotated;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL euclidean_pattern_generator");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_masks.size() == 0) begin
				$error("hit_mask: unexpected result %h", hit_mask);
				error_count++;
			end else begin
				if (hit_mask !== pending_masks[0]) begin
					$error("hit_mask: expected %h, actual %h", pending_masks[0], hit_mask);
					error_count++;
				end
				void'(pending_masks.pop_front());
				masks_checked++;
			end
		end
	end

	task automatic send_pattern_item(
		input logic [LEN_W-1:0] steps_in,
		input logic [LEN_W-1:0] pulses_in,
		input logic [ROT_W-1:0] rot_in
	);
		@(negedge clk);
		step_count = steps_in;
		pulse_count = pulses_in;
		rotate_by = rot_in;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_masks = {pending_masks, predict_hit_mask(steps_in, pulses_in, rot_in)};
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic sender_gap();
		if (gaps_enabled && $urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				do
					@(posedge clk);
				while (busy);
			end
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	task automatic wait_for_masks();
		while (pending_masks.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_pattern_item(
		output logic [LEN_W-1:0] steps_out,
		output logic [LEN_W-1:0] pulses_out,
		output logic [ROT_W-1:0] rot_out,
		input  bit               wide_rotation
	);
		int len;
		if ($urandom_range(0, 9) < 7) begin
			len = $urandom_range(2, MAX_STEPS);
			steps_out = LEN_W'(len);
			pulses_out = LEN_W'($urandom_range(1, len - 1));
		end else begin
			steps_out = LEN_W'($urandom);
			pulses_out = LEN_W'($urandom);
		end
		case ($urandom_range(0, 3))
			0: rot_out = ROT_W'($urandom_range(0, 140) - 70);
			1: rot_out = wide_rotation ? ROT_W'(32767 - $urandom_range(0, 40))
			                           : ROT_W'($urandom_range(0, 63));
			2: rot_out = wide_rotation ? ROT_W'($urandom_range(0, 40) - 32768)
			                           : ROT_W'(-$urandom_range(0, 63));
			default: rot_out = ROT_W'($urandom);
		endcase
	endtask

	task automatic test_directed_cases();
		send_pattern_item(6'd8, 6'd3, 16'sd0);
		send_pattern_item(6'd8, 6'd3, -16'sd1);
		send_pattern_item(6'd8, 6'd5, 16'sd3);
		send_pattern_item(6'd0, 6'd0, 16'sd5);
		send_pattern_item(6'd0, 6'd63, -16'sd7);
		send_pattern_item(6'd1, 6'd1, 16'sd32767);
		send_pattern_item(6'd32, 6'd0, 16'h8000);
		send_pattern_item(6'd63, 6'd63, -16'sd1);
		send_pattern_item(6'd33, 6'd17, 16'sd9);
		send_pattern_item(6'd32, 6'd31, 16'h8000);
		send_pattern_item(6'd32, 6'd1, 16'sd32767);
		send_pattern_item(6'd32, 6'd32, 16'sd13);
		send_pattern_item(6'd5, 6'd0, -16'sd1);
		send_pattern_item(6'd5, 6'd40, -16'sd2);
		send_pattern_item(6'd13, 6'd5, -16'sd13);
		send_pattern_item(6'd12, 6'd7, 16'sd24);
		send_pattern_item(6'd32, 6'd17, -16'sd33);
		send_pattern_item(6'd31, 6'd30, 16'sd1);
		send_pattern_item(6'd2, 6'd1, -16'sd3);
		send_pattern_item(6'd7, 6'd3, 16'h5555);
		send_pattern_item(6'd63, 6'd5, 16'hAAAA);
		send_pattern_item(6'd16, 6'd9, 16'h7FF0);
		send_pattern_item(6'd3, 6'd2, 16'h8001);
		send_pattern_item(6'd24, 6'd11, -16'sd25);
	endtask

	task automatic test_random_mixed(input int count);
		logic [LEN_W-1:0] s;
		logic [LEN_W-1:0] p;
		logic [ROT_W-1:0] r;
		repeat (count) begin
			random_pattern_item(s, p, r, 1'b0);
			send_pattern_item(s, p, r);
			sender_gap();
		end
	endtask

	task automatic test_drain_pause();
		logic [LEN_W-1:0] s;
		logic [LEN_W-1:0] p;
		logic [ROT_W-1:0] r;
		repeat (6) begin
			random_pattern_item(s, p, r, 1'b1);
			send_pattern_item(s, p, r);
		end
		wait_for_masks();
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic test_rotation_extremes(input int count);
		logic [LEN_W-1:0] s;
		logic [LEN_W-1:0] p;
		logic [ROT_W-1:0] r;
		repeat (count) begin
			random_pattern_item(s, p, r, 1'b1);
			send_pattern_item(s, p, r);
			sender_gap();
		end
	endtask

	task automatic test_back_to_back(input int count);
		logic [LEN_W-1:0] s;
		logic [LEN_W-1:0] p;
		logic [ROT_W-1:0] r;
		gaps_enabled = 1'b0;
		repeat (count) begin
			random_pattern_item(s, p, r, 1'($urandom_range(0, 1)));
			send_pattern_item(s, p, r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		step_count = '0;
		pulse_count = '0;
		rotate_by = '0;
		items_sent = 0;
		masks_checked = 0;
		error_count = 0;
		cycle_count = 0;
		gaps_enabled = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_mixed(600);
		test_drain_pause();
		test_rotation_extremes(300);
		test_back_to_back(370);

		wait_for_masks();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_masks.size() != 0) begin
			$error("hit_mask: %0d expected results never arrived", pending_masks.size());
			error_count++;
		end
		$display("covered clamps, empty/full patterns, floored rotations: %0d items, %0d masks",
			items_sent, masks_checked);
		if (error_count == 0)
			$display("PASS euclidean_pattern_generator");
		else
			$display("FAIL euclidean_pattern_generator");
		$finish;
	end

endmodule

`default_nettype wire

// ===== euclidean_pattern_generator.f =====
+incdir+rtl/core
rtl/core/epg_pkg.sv
rtl/core/epg_reduce.sv
rtl/core/euclidean_pattern_generator.sv
sim/tb_euclidean_pattern_generator.sv
